>>> sv/sbl_pkg.sv
`default_nettype none
package sbl_pkg;

    // Reading buffer geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int MAX_RESULTS  = 16;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int IDX_W        = $clog2(MAX_RESULTS);
    localparam int NUM_W        = $clog2(MAX_RESULTS + 1);

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_HUM_DELTA  = 2'd0;
    localparam logic [1:0] REG_TEMP_DELTA = 2'd1;
    localparam logic [1:0] REG_BATCH_SIZE = 2'd2;

    localparam logic [15:0] HUM_DELTA_RST  = 16'd500;
    localparam logic [15:0] TEMP_DELTA_RST = 16'd100;
    localparam logic [4:0]  BATCH_SIZE_RST = 5'd8;

    // Event codes
    localparam logic [2:0] ACT_START       = 3'd0;
    localparam logic [2:0] ACT_INITIALIZED = 3'd1;
    localparam logic [2:0] ACT_WAKE        = 3'd2;
    localparam logic [2:0] ACT_READING     = 3'd3;
    localparam logic [2:0] ACT_SENT        = 3'd4;
    localparam logic [2:0] ACT_BLINKED     = 3'd5;
    localparam logic [2:0] ACT_ERROR       = 3'd6;

    // Command codes
    localparam logic [2:0] CMD_INIT   = 3'd0;
    localparam logic [2:0] CMD_TAKE   = 3'd1;
    localparam logic [2:0] CMD_SLEEP  = 3'd2;
    localparam logic [2:0] CMD_SEND   = 3'd3;
    localparam logic [2:0] CMD_FATAL  = 3'd4;
    localparam logic [2:0] CMD_SINGLE = 3'd5;

    // Error codes
    localparam logic [7:0] ERR_FULL     = 8'd0;
    localparam logic [7:0] ERR_MISMATCH = 8'd1;
    localparam logic [7:0] ERR_NONE     = 8'd0;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [13:0]        hum;
    } reading_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_ctl_t;

endpackage
`default_nettype wire

>>> sv/sbl_store.sv
`default_nettype none
module sbl_store (
    input  wire logic              aclk,
    input  wire sbl_pkg::store_ctl_t ctl,
    input  wire sbl_pkg::reading_t wr_data,
    output sbl_pkg::reading_t      rd_data
);
    import sbl_pkg::*;

    reading_t mem [BUFFER_DEPTH];
    reading_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

>>> sv/sbl_cmp.sv
`default_nettype none
module sbl_cmp (
    input  wire logic signed [16:0] latest,
    input  wire logic signed [16:0] first,
    input  wire logic [15:0]        delta,
    output logic                    exceeds
);
    import sbl_pkg::*;

    logic signed [17:0] rise;

    // Signed rise against the unsigned threshold
    always_comb begin
        rise    = 18'(latest) - 18'(first);
        exceeds = rise > $signed({2'b00, delta});
    end

endmodule
`default_nettype wire

>>> sv/sensor_batch_logger_fsm.sv
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser: action; s_tdata: temperature, humidity, error_in
// m_        out  m_tvalid/m_tready  m_tuser: command; m_tdata: error_out, out_temperature,
//                                   out_humidity, reading_index; m_tlast: last
// APB       in   psel/penable/pready registers: humidity delta, temperature delta, batch size
//
// An event is latched, decoded, and then loaded into the output register;
// a reading with more than two held also makes two passes through the shared
// subtract/compare unit. A transmit replays its n readings at one beat per cycle, while
// m_tready stays high, from the single read port of the reading buffer.
// aresetn is synchronous, active low; it clears phase, held count, sequencer and registers.
// The buffer has no reset; only entries written since the last start are read.
// m_tready low holds a valid output register and stalls the sequencer in its send and emit states until it drains.
module sensor_batch_logger_fsm (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // s_tdata: [15:0] temperature, [29:16] humidity, [37:30] error_in
    input  wire logic [sbl_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: [2:0] action
    input  wire logic [2:0]                      s_tuser,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // m_tdata: [7:0] error_out, [23:8] out_temperature, [37:24] out_humidity,
    //          [41:38] reading_index
    output logic [sbl_pkg::M_TDATA_W-1:0]        m_tdata,
    // m_tuser: [2:0] command
    output logic [2:0]                           m_tuser,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sbl_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import sbl_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DECIDE   = 7'b0000010,
        S_CMP_HUM  = 7'b0000100,
        S_CMP_TEMP = 7'b0001000,
        S_FETCH    = 7'b0010000,
        S_SEND     = 7'b0100000,
        S_EMIT     = 7'b1000000
    } seq_t;

    typedef enum logic [4:0] {
        PH_UNSTARTED = 5'b00001,
        PH_INIT      = 5'b00010,
        PH_TAKING    = 5'b00100,
        PH_WAITING   = 5'b01000,
        PH_TRANSMIT  = 5'b10000
    } phase_t;

    // Configuration registers
    logic [15:0] hum_delta_reg;
    logic [15:0] temp_delta_reg;
    logic [4:0]  batch_size_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_sel;

    // Sequencer and block state
    seq_t              state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [CNT_W-1:0]  held_inc;
    logic              dev_reg, dev_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [NUM_W-1:0]  n_reg, n_next;
    logic [2:0]        pend_cmd_reg, pend_cmd_next;
    logic [7:0]        pend_err_reg, pend_err_next;

    // Latched event
    logic [2:0]        act_reg;
    reading_t          in_rd_reg;
    logic [7:0]        err_in_reg;
    logic              s_accept;

    // Buffer and shared compare unit
    store_ctl_t        ctl;
    reading_t          rd_data;
    logic signed [16:0] cmp_latest;
    logic signed [16:0] cmp_first;
    logic [15:0]       cmp_delta;
    logic              cmp_exceeds;

    // Output register
    logic                 out_free;
    logic                 out_load;
    logic [2:0]           out_cmd;
    logic [7:0]           out_err;
    reading_t             out_rd;
    logic [3:0]           out_idx;
    logic                 out_last;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [2:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    function automatic logic [NUM_W-1:0] clip_count(input logic [CNT_W-1:0] h);
        if (32'(h) >= 32'(MAX_RESULTS)) begin
            return NUM_W'(MAX_RESULTS);
        end
        return NUM_W'(h);
    endfunction

    function automatic logic count_hit(input logic [CNT_W-1:0] h, input logic [4:0] b);
        return 32'(h) >= 32'(b);
    endfunction

    // APB register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hum_delta_reg  <= HUM_DELTA_RST;
            temp_delta_reg <= TEMP_DELTA_RST;
            batch_size_reg <= BATCH_SIZE_RST;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_HUM_DELTA:  hum_delta_reg  <= pwdata[15:0];
                REG_TEMP_DELTA: temp_delta_reg <= pwdata[15:0];
                REG_BATCH_SIZE: batch_size_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_HUM_DELTA:  prdata = {16'd0, hum_delta_reg};
            REG_TEMP_DELTA: prdata = {16'd0, temp_delta_reg};
            REG_BATCH_SIZE: prdata = {27'd0, batch_size_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Input latch
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg        <= s_tuser;
            in_rd_reg.temp <= s_tdata[15:0];
            in_rd_reg.hum  <= s_tdata[29:16];
            err_in_reg     <= s_tdata[37:30];
        end
    end

    sbl_store u_store (
        .aclk    (aclk),
        .ctl     (ctl),
        .wr_data (in_rd_reg),
        .rd_data (rd_data)
    );

    // Humidity pass first, temperature pass second
    always_comb begin
        if (state_reg == S_CMP_HUM) begin
            cmp_latest = $signed({3'b000, in_rd_reg.hum});
            cmp_first  = $signed({3'b000, rd_data.hum});
            cmp_delta  = hum_delta_reg;
        end else begin
            cmp_latest = 17'(in_rd_reg.temp);
            cmp_first  = 17'(rd_data.temp);
            cmp_delta  = temp_delta_reg;
        end
    end

    sbl_cmp u_cmp (
        .latest  (cmp_latest),
        .first   (cmp_first),
        .delta   (cmp_delta),
        .exceeds (cmp_exceeds)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign held_inc = held_reg + CNT_W'(1);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        held_next     = held_reg;
        dev_next      = dev_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        pend_cmd_next = pend_cmd_reg;
        pend_err_next = pend_err_reg;
        ctl           = '0;
        out_load      = 1'b0;
        out_cmd       = pend_cmd_reg;
        out_err       = pend_err_reg;
        out_rd        = '0;
        out_idx       = '0;
        out_last      = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                state_next    = S_EMIT;
                pend_err_next = ERR_NONE;
                pend_cmd_next = CMD_FATAL;
                dev_next      = 1'b0;
                unique case (act_reg)
                    ACT_START: begin
                        phase_next    = PH_INIT;
                        held_next     = '0;
                        pend_cmd_next = CMD_INIT;
                    end
                    ACT_INITIALIZED: begin
                        if (phase_reg == PH_INIT) begin
                            phase_next    = PH_TAKING;
                            pend_cmd_next = CMD_TAKE;
                        end else begin
                            pend_err_next = ERR_MISMATCH;
                        end
                    end
                    ACT_WAKE: begin
                        if (phase_reg == PH_WAITING) begin
                            phase_next    = PH_TAKING;
                            pend_cmd_next = CMD_TAKE;
                        end else begin
                            pend_err_next = ERR_MISMATCH;
                        end
                    end
                    ACT_READING: begin
                        if (phase_reg != PH_TAKING) begin
                            pend_err_next = ERR_MISMATCH;
                        end else if (held_reg == CNT_W'(BUFFER_DEPTH)) begin
                            pend_err_next = ERR_FULL;
                        end else begin
                            // store, then either compare against entry 0 or test count
                            ctl.wr_en   = 1'b1;
                            ctl.wr_addr = ADDR_W'(held_reg);
                            held_next   = held_inc;
                            if (32'(held_reg) >= 32'd2) begin
                                ctl.rd_en   = 1'b1;
                                ctl.rd_addr = '0;
                                state_next  = S_CMP_HUM;
                            end else if (count_hit(held_inc, batch_size_reg)) begin
                                phase_next = PH_TRANSMIT;
                                n_next     = clip_count(held_inc);
                                state_next = S_FETCH;
                            end else begin
                                phase_next    = PH_WAITING;
                                pend_cmd_next = CMD_SLEEP;
                            end
                        end
                    end
                    ACT_SENT: begin
                        if (phase_reg == PH_TRANSMIT) begin
                            held_next     = '0;
                            phase_next    = PH_WAITING;
                            pend_cmd_next = CMD_SLEEP;
                        end else if (phase_reg == PH_TAKING) begin
                            pend_cmd_next = CMD_TAKE;
                        end else begin
                            pend_err_next = ERR_MISMATCH;
                        end
                    end
                    ACT_BLINKED: begin
                        if (phase_reg == PH_TRANSMIT) begin
                            phase_next    = PH_WAITING;
                            pend_cmd_next = CMD_SLEEP;
                        end else if (phase_reg == PH_TAKING) begin
                            pend_cmd_next = CMD_TAKE;
                        end else begin
                            pend_err_next = ERR_MISMATCH;
                        end
                    end
                    ACT_ERROR: begin
                        pend_cmd_next = CMD_SINGLE;
                        pend_err_next = err_in_reg;
                    end
                    default: begin
                        pend_err_next = ERR_MISMATCH;
                    end
                endcase
            end

            S_CMP_HUM: begin
                dev_next   = cmp_exceeds;
                state_next = S_CMP_TEMP;
            end

            S_CMP_TEMP: begin
                if (dev_reg || cmp_exceeds || count_hit(held_reg, batch_size_reg)) begin
                    phase_next = PH_TRANSMIT;
                    n_next     = clip_count(held_reg);
                    state_next = S_FETCH;
                end else begin
                    phase_next    = PH_WAITING;
                    pend_cmd_next = CMD_SLEEP;
                    pend_err_next = ERR_NONE;
                    state_next    = S_EMIT;
                end
            end

            S_FETCH: begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = '0;
                k_next      = '0;
                state_next  = S_SEND;
            end

            S_SEND: begin
                // one buffered reading per beat; prefetch the next as this one loads
                out_cmd  = CMD_SEND;
                out_err  = ERR_NONE;
                out_rd   = rd_data;
                out_idx  = 4'(k_reg);
                out_last = (NUM_W'(k_reg) + NUM_W'(1)) == n_reg;
                if (out_free) begin
                    out_load = 1'b1;
                    if (out_last) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next      = k_reg + IDX_W'(1);
                        ctl.rd_en   = 1'b1;
                        ctl.rd_addr = ADDR_W'(k_reg + IDX_W'(1));
                    end
                end
            end

            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= PH_UNSTARTED;
            held_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        dev_reg      <= dev_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        pend_cmd_reg <= pend_cmd_next;
        pend_err_reg <= pend_err_next;
    end

    // Output register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {6'd0, out_idx, out_rd.hum, out_rd.temp, out_err};
            m_tuser_reg <= out_cmd;
            m_tlast_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
`default_nettype wire
